// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// Depends on nothing; expects a clock named clk and a reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, suppressed while rst is high.
`define RPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define RPE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/rpe_pkg.sv =====
// Shared types, constants and the round/saturate function of the rotary embedding core.
// Depends on nothing.
package rpe_pkg;

  localparam int MAX_ROW_DEF = 128;
  localparam int X_W         = 16;
  localparam int POS_W       = 7;
  localparam int HD_W        = 7;
  localparam int HD_RESET    = 64;
  localparam int CMP_W       = 9;
  localparam int PROD_W      = 32;
  localparam int SUM_W       = 34;
  localparam int FRAC_W      = 14;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = 2;
  localparam int ITEM_W      = 3 * X_W;

  typedef struct packed {
    logic signed [X_W-1:0] z;
    logic                  sat;
  } zsat_t;

  typedef struct packed {
    logic [POS_W-1:0] pos_lo;
    zsat_t            res_lo;
    logic [POS_W-1:0] pos_hi;
    zsat_t            res_hi;
    logic             last;
  } pair_t;

  // Round half up by FRAC_W bits, then clip to signed X_W bits.
  function automatic zsat_t round_sat(input logic signed [SUM_W-1:0] sum);
    logic signed [SUM_W-1:0]        t;
    logic signed [SUM_W-FRAC_W-1:0] r;
    zsat_t                          o;
    t = sum + SUM_W'(1 << (FRAC_W - 1));
    r = t[SUM_W-1:FRAC_W];
    if (r > (SUM_W-FRAC_W)'(32767)) begin
      o.z   = 16'sh7fff;
      o.sat = 1'b1;
    end else if (r < -(SUM_W-FRAC_W)'(32768)) begin
      o.z   = 16'sh8000;
      o.sat = 1'b1;
    end else begin
      o.z   = r[X_W-1:0];
      o.sat = 1'b0;
    end
    return o;
  endfunction

endpackage

// ===== hw/rtl/rotary_position_embedding_core.sv =====
// Rotary position embedding (rotate-half) core, top level.
// Depends on rpe_pkg, rpe_ram and assert_macros.svh.
// A second-half word: partner read from RAM, products registered, result pair into the queue.
// Throughput: first-half words 1 per cycle; second-half words need queue room (two results).
// First-half words are held in a 48-bit RAM; a result pair queue of 4 entries feeds the output.
// Reset: position 0, half_dim 64, pipeline and queue empty; RAM contents are not cleared.
`include "assert_macros.svh"

module rotary_position_embedding_core
  import rpe_pkg::*;
#(
  parameter int MAX_ROW = MAX_ROW_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              half_dim_wr,
  input  logic [HD_W-1:0]   half_dim,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [ITEM_W-1:0] s_axis_tdata,   // x_value, cos_value, sin_value
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [23:0]       m_axis_tdata,   // position, z_value, pad
  output logic [0:0]        m_axis_tuser,   // saturated
  output logic              m_axis_tlast    // row_end
);

  localparam int HALF_DEPTH = MAX_ROW / 2;
  localparam int AW         = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
  localparam int PW         = $clog2(MAX_ROW);

  logic [HD_W-1:0]   hd_reg;
  logic [PW-1:0]     pos;
  logic [CMP_W-1:0]  h9, two_h, pos9, p_eff, idx9, p_inc;
  logic              first_half, row_last, room, accept;

  always_comb begin
    h9 = CMP_W'(hd_reg);
    if (h9 == '0) begin
      h9 = CMP_W'(1);
    end else if (h9 > CMP_W'(HALF_DEPTH)) begin
      h9 = CMP_W'(HALF_DEPTH);
    end
    two_h      = h9 << 1;
    pos9       = CMP_W'(pos);
    p_eff      = (pos9 >= two_h) ? '0 : pos9;
    first_half = p_eff < h9;
    idx9       = p_eff - h9;
    p_inc      = p_eff + CMP_W'(1);
    row_last   = p_inc == two_h;
  end

  // result pair queue
  pair_t               fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr, rd_ptr;
  logic [FIFO_AW:0]    fifo_cnt;
  logic                sel;
  logic                push, pop;

  logic v1, v2;

  assign room          = (fifo_cnt + (FIFO_AW+1)'(v1) + (FIFO_AW+1)'(v2))
                         < (FIFO_AW+1)'(FIFO_DEPTH);
  assign s_axis_tready = first_half || room;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hd_reg <= HD_W'(HD_RESET);
      pos    <= '0;
    end else if (half_dim_wr) begin
      hd_reg <= half_dim;
      pos    <= '0;
    end else if (accept) begin
      pos <= row_last ? '0 : p_inc[PW-1:0];
    end
  end

  logic [ITEM_W-1:0] ram_rdata;

  rpe_ram #(
    .WIDTH (ITEM_W),
    .DEPTH (HALF_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (accept && first_half),
    .waddr (p_eff[AW-1:0]),
    .wdata (s_axis_tdata),
    .re    (accept && !first_half),
    .raddr (idx9[AW-1:0]),
    .rdata (ram_rdata)
  );

  // stage 1: partner read from RAM
  logic signed [X_W-1:0] xj1, cj1, sj1;
  logic [POS_W-1:0]      pj1, pi1;
  logic                  last1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept && !first_half;
    end
    xj1   <= s_axis_tdata[X_W-1:0];
    cj1   <= s_axis_tdata[2*X_W-1:X_W];
    sj1   <= s_axis_tdata[3*X_W-1:2*X_W];
    pj1   <= p_eff[POS_W-1:0];
    pi1   <= idx9[POS_W-1:0];
    last1 <= row_last;
  end

  logic signed [X_W-1:0] xi1, ci1, si1;
  assign xi1 = ram_rdata[X_W-1:0];
  assign ci1 = ram_rdata[2*X_W-1:X_W];
  assign si1 = ram_rdata[3*X_W-1:2*X_W];

  // stage 2: products
  logic signed [PROD_W-1:0] pa, pb, pc, pd;
  logic [POS_W-1:0]         pj2, pi2;
  logic                     last2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    pa    <= PROD_W'(xi1) * PROD_W'(ci1);
    pb    <= PROD_W'(xj1) * PROD_W'(si1);
    pc    <= PROD_W'(xj1) * PROD_W'(cj1);
    pd    <= PROD_W'(xi1) * PROD_W'(sj1);
    pj2   <= pj1;
    pi2   <= pi1;
    last2 <= last1;
  end

  logic signed [SUM_W-1:0] sum_lo, sum_hi;
  pair_t                   pair_in;

  always_comb begin
    sum_lo = {{(SUM_W-PROD_W){pa[PROD_W-1]}}, pa} - {{(SUM_W-PROD_W){pb[PROD_W-1]}}, pb};
    sum_hi = {{(SUM_W-PROD_W){pc[PROD_W-1]}}, pc} + {{(SUM_W-PROD_W){pd[PROD_W-1]}}, pd};
    pair_in.pos_lo = pi2;
    pair_in.res_lo = round_sat(sum_lo);
    pair_in.pos_hi = pj2;
    pair_in.res_hi = round_sat(sum_hi);
    pair_in.last   = last2;
  end

  assign push = v2;
  assign pop  = m_axis_tvalid && m_axis_tready && sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
      sel      <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sel <= !sel;
      end
      fifo_cnt <= fifo_cnt + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= pair_in;
    end
  end

  pair_t            head;
  logic [POS_W-1:0] out_pos;
  zsat_t            out_res;

  assign head          = fifo_mem[rd_ptr];
  assign out_pos       = sel ? head.pos_hi : head.pos_lo;
  assign out_res       = sel ? head.res_hi : head.res_lo;
  assign m_axis_tvalid = fifo_cnt != '0;
  assign m_axis_tdata  = {1'b0, out_res.z, out_pos};
  assign m_axis_tuser  = out_res.sat;
  assign m_axis_tlast  = sel && head.last;

  `RPE_ASSERT(a_credit, ((fifo_cnt + (FIFO_AW+1)'(v1) + (FIFO_AW+1)'(v2)) <= (FIFO_AW+1)'(FIFO_DEPTH)), "result queue overcommitted")
  `RPE_ASSERT(a_first_no_result, (accept && first_half) |=> !v1, "first-half word entered the datapath")
  `RPE_ASSERT(a_last_second, (m_axis_tvalid && m_axis_tlast) |-> sel, "row end on first word of a pair")
  `RPE_ASSERT(a_cfg_restart, half_dim_wr |=> (pos == '0), "config write did not restart the row")
  `RPE_ASSERT(a_sel_empty, (fifo_cnt == '0) |-> !sel, "pair select set with empty queue")

endmodule

// ===== hw/rtl/rpe_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module rpe_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for rotary_position_embedding_core (rotate-half RoPE).
// Streams x/cos/sin words in, predicts every rotated result and checks it on the output.
// Depends on rpe_pkg and the core RTL only.
module testbench
  import rpe_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_DEPTH    = MAX_ROW_DEF / 2;
  localparam int Q_FRAC        = 14;
  localparam int RANDOM_WORDS  = 1330;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef enum logic {STEP_WORD, STEP_CFG} step_kind_t;

  typedef struct {
    step_kind_t            kind;
    logic [HD_W-1:0]       hd;
    logic signed [X_W-1:0] x;
    logic signed [X_W-1:0] c;
    logic signed [X_W-1:0] s;
    bit                    typed;
    logic signed [X_W-1:0] z_lo;
    bit                    sat_lo;
    logic signed [X_W-1:0] z_hi;
    bit                    sat_hi;
  } step_t;

  typedef struct {
    logic [POS_W-1:0]      pos;
    logic signed [X_W-1:0] z;
    bit                    sat;
    bit                    last;
  } z_result_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              half_dim_wr = 1'b0;
  logic [HD_W-1:0]   half_dim = HD_W'(HD_RESET);
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [ITEM_W-1:0] s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [23:0]       m_axis_tdata;
  logic [0:0]        m_axis_tuser;
  logic              m_axis_tlast;

  rotary_position_embedding_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .half_dim_wr   (half_dim_wr),
    .half_dim      (half_dim),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // predictor state
  logic signed [X_W-1:0] stored_x [HALF_DEPTH];
  logic signed [X_W-1:0] stored_c [HALF_DEPTH];
  logic signed [X_W-1:0] stored_s [HALF_DEPTH];
  int                    row_pos;
  logic [HD_W-1:0]       hd_reg;
  z_result_t             z_expected_q[$];
  step_t                 directed_steps[$];

  int errors       = 0;
  int words_sent   = 0;
  int results_seen = 0;
  int sat_seen     = 0;
  int cfg_writes   = 0;
  int cycle_count  = 0;
  int stall_left   = 0;
  bit calm         = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int eff_half();
    if (hd_reg == 0) return 1;
    if (hd_reg > HALF_DEPTH) return HALF_DEPTH;
    return int'(hd_reg);
  endfunction

  // round half up by Q_FRAC bits, then clip to 16 bits
  function automatic void round_clip(input longint sum, output logic signed [X_W-1:0] z,
                                     output bit sat);
    longint r;
    r = (sum + 8192) >>> Q_FRAC;
    if (r > 32767) begin
      z = 16'sh7fff;
      sat = 1'b1;
    end else if (r < -32768) begin
      z = 16'sh8000;
      sat = 1'b1;
    end else begin
      z = r[X_W-1:0];
      sat = 1'b0;
    end
  endfunction

  function automatic int rotate_predict(input logic signed [X_W-1:0] x, c, s,
                                        output z_result_t lo, output z_result_t hi);
    int     h;
    int     p;
    int     i;
    longint s0;
    longint s1;
    h = eff_half();
    p = row_pos;
    if (p >= 2 * h) p = 0;
    if (p < h) begin
      stored_x[p] = x;
      stored_c[p] = c;
      stored_s[p] = s;
      row_pos = p + 1;
      return 0;
    end
    i = p - h;
    s0 = longint'(stored_x[i]) * longint'(stored_c[i]) - longint'(x) * longint'(stored_s[i]);
    s1 = longint'(x) * longint'(c) + longint'(stored_x[i]) * longint'(s);
    lo.pos = POS_W'(i);
    round_clip(s0, lo.z, lo.sat);
    lo.last = 1'b0;
    hi.pos = POS_W'(p);
    round_clip(s1, hi.z, hi.sat);
    hi.last = (p == 2 * h - 1);
    row_pos = (p + 1 >= 2 * h) ? 0 : p + 1;
    return 2;
  endfunction

  function automatic logic signed [X_W-1:0] rand_x();
    case ($urandom_range(0, 11))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return X_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [X_W-1:0] rand_trig();
    case ($urandom_range(0, 9))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'sd0;
      default: return X_W'(int'($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic logic [HD_W-1:0] pick_half_dim();
    case ($urandom_range(0, 19))
      0: return HD_W'(0);
      1: return HD_W'(1);
      2: return HD_W'(HALF_DEPTH);
      3: return HD_W'($urandom_range(HALF_DEPTH + 1, 126));
      4: return 7'd127;
      5, 6, 7: return HD_W'($urandom_range(2, 4));
      8, 9: return HD_W'($urandom_range(17, HALF_DEPTH - 1));
      default: return HD_W'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic void cfg_step(input logic [HD_W-1:0] hd);
    step_t st;
    st = '{kind: STEP_CFG, hd: hd, default: '0};
    directed_steps.push_back(st);
  endfunction

  function automatic void word_step(input logic signed [X_W-1:0] x, c, s,
                                   input bit typed = 1'b0,
                                   input logic signed [X_W-1:0] zl = '0, input bit sl = 1'b0,
                                   input logic signed [X_W-1:0] zh = '0, input bit sh = 1'b0);
    step_t st;
    st.kind   = STEP_WORD;
    st.hd     = '0;
    st.x      = x;
    st.c      = c;
    st.s      = s;
    st.typed  = typed;
    st.z_lo   = zl;
    st.sat_lo = sl;
    st.z_hi   = zh;
    st.sat_hi = sh;
    directed_steps.push_back(st);
  endfunction

  // entered and left at a falling edge
  task automatic send_word(input step_t st);
    z_result_t lo;
    z_result_t hi;
    int        n;
    int        gap;
    gap = calm ? 0 : gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {st.s, st.c, st.x};
    do @(posedge clk); while (!s_axis_tready);
    n = rotate_predict(st.x, st.c, st.s, lo, hi);
    if (n == 2) begin
      if (st.typed) begin
        lo.z   = st.z_lo;
        lo.sat = st.sat_lo;
        hi.z   = st.z_hi;
        hi.sat = st.sat_hi;
      end
      z_expected_q.push_back(lo);
      z_expected_q.push_back(hi);
    end
    words_sent++;
    @(negedge clk);
  endtask

  // only while idle: all results in, pipeline drained
  task automatic write_half_dim(input logic [HD_W-1:0] v);
    s_axis_tvalid <= 1'b0;
    while (z_expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    half_dim_wr <= 1'b1;
    half_dim    <= v;
    hd_reg  = v;
    row_pos = 0;
    cfg_writes++;
    @(negedge clk);
    half_dim_wr <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left = calm ? 0 : gap_len();
    end
  end

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    z_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (m_axis_tuser[0]) sat_seen++;
      if (z_expected_q.size() == 0) begin
        $error("unexpected result word at position %0d", m_axis_tdata[POS_W-1:0]);
        errors++;
      end else begin
        want = z_expected_q.pop_front();
        check_field("position", int'(want.pos), int'(m_axis_tdata[POS_W-1:0]));
        check_field("z_value", int'(want.z), int'($signed(m_axis_tdata[POS_W+X_W-1:POS_W])));
        check_field("saturated", int'(want.sat), int'(m_axis_tuser[0]));
        check_field("row_end", int'(want.last), int'(m_axis_tlast));
      end
    end
  end

  initial begin
    step_t st;
    int    h;
    int    words;
    int    rows;

    hd_reg  = HD_W'(HD_RESET);
    row_pos = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // first-half words at the reset setting, then a write drops the partial row
    word_step(16'sd1234, 16'sd16384, 16'sd0);
    word_step(-16'sd5, -16'sd16384, 16'sd16384);
    word_step(16'sd32767, 16'sd0, -16'sd1);
    cfg_step(7'd1);
    word_step(16'sd1000, 16'sd16384, 16'sd0);
    word_step(16'sd2000, 16'sd16384, 16'sd0, 1'b1, 16'sd1000, 1'b0, 16'sd2000, 1'b0);
    // positive clip on z[i]
    word_step(16'sd32767, 16'sd16384, 16'sd16384);
    word_step(-16'sd32768, 16'sd16384, 16'sd16384, 1'b1, 16'sd32767, 1'b1, -16'sd1, 1'b0);
    // negative clip on both
    word_step(-16'sd32768, 16'sd16384, 16'sd16384);
    word_step(16'sd32767, -16'sd16384, 16'sd16384, 1'b1,
              -16'sd32768, 1'b1, -16'sd32768, 1'b1);
    // most negative x times -1.0
    word_step(-16'sd32768, -16'sd16384, 16'sd0);
    word_step(16'sd0, 16'sd0, 16'sd0, 1'b1, 16'sd32767, 1'b1, 16'sd0, 1'b0);
    // exact halves round up
    word_step(16'sd1, 16'sd8192, 16'sd0);
    word_step(-16'sd1, 16'sd8192, 16'sd0, 1'b1, 16'sd1, 1'b0, 16'sd0, 1'b0);
    // half_dim zero acts as one
    cfg_step(7'd0);
    word_step(16'sd100, 16'sd16384, 16'sd0);
    word_step(-16'sd100, 16'sd16384, 16'sd16384, 1'b1, 16'sd100, 1'b0, 16'sd0, 1'b0);
    cfg_step(7'd2);
    word_step(-16'sd32768, -16'sd16384, 16'sd16384);
    word_step(16'sd32767, 16'sd16384, -16'sd16384);
    word_step(16'sd12345, -16'sd16384, -16'sd1);
    word_step(-16'sd1, 16'sd1, 16'sd16384);

    foreach (directed_steps[k]) begin
      if (directed_steps[k].kind == STEP_CFG) begin
        write_half_dim(directed_steps[k].hd);
      end else begin
        send_word(directed_steps[k]);
      end
    end

    // random phases: full rows with random content, sometimes a trailing partial row
    words = 0;
    while (words < RANDOM_WORDS) begin
      write_half_dim(pick_half_dim());
      calm = ($urandom_range(0, 4) == 0);
      h = eff_half();
      rows = (h >= 17) ? 1 : $urandom_range(1, 6);
      rows = rows * 2 * h;
      if ($urandom_range(0, 3) == 0) rows += $urandom_range(1, 2 * h - 1);
      repeat (rows) begin
        st.kind  = STEP_WORD;
        st.x     = rand_x();
        st.c     = rand_trig();
        st.s     = rand_trig();
        st.typed = 1'b0;
        send_word(st);
      end
      words += rows;
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (z_expected_q.size() != 0) @(posedge clk);
    repeat (4 * SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d words over %0d half_dim writes; checked %0d results, %0d saturated.",
             words_sent, cfg_writes, results_seen, sat_seen);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
